// ===== sv/sirt_pkg.sv =====
package sirt_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef logic [3:0] t_digit;

    localparam int DIGITS_MAX = 32;
    localparam int STEPS      = 8;

    localparam logic [1:0] CFG_SYMBOL_COUNT = 2'd0;
    localparam logic [1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [1:0] CFG_SYMBOLS_HIGH = 2'd2;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    localparam logic [4:0]  RST_SYMBOL_COUNT = 5'd10;
    localparam logic [63:0] RST_SYMBOLS_LOW  = 64'h3736353433323130;
    localparam logic [63:0] RST_SYMBOLS_HIGH = 64'h0000000000003938;

endpackage

// ===== sv/signed_int_to_radix_text.sv =====
// Steps: accept the value, then divide by the radix once per digit over the bit length of the
// remaining quotient (all 32 bits on the first digit), then emit one character at a time.
// The shared divide unit retires eight dividend bits per cycle. One item is in work at a time.
// Reset is synchronous and active low: it clears control state and restores the decimal
// alphabet "0123456789".
module signed_int_to_radix_text
    import sirt_pkg::*;
#(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_out_char,
    output logic               o_is_last
);

    t_state r_state, n_state;

    logic [4:0]  r_symbol_count;
    logic [63:0] r_symbols_low;
    logic [63:0] r_symbols_high;

    logic [31:0] r_work, n_work;
    logic [5:0]  r_cnt, n_cnt;
    logic [3:0]  r_rem, n_rem;
    logic [5:0]  r_nlen, n_nlen;
    t_digit [DIGITS_MAX-1:0] r_stack, n_stack;
    logic [5:0]  r_nd, n_nd;
    logic        r_neg, n_neg;
    logic        r_ovalid, n_ovalid;
    logic [7:0]  r_ochar, n_ochar;
    logic        r_olast, n_olast;

    logic [15:0][7:0] w_sym;
    logic        w_alpha_ok;
    logic        w_start;
    logic        w_emit_load;
    logic        w_last_load;
    logic        w_div_done;
    logic [31:0] w_work;
    logic [3:0]  w_rem;
    logic [5:0]  w_nlen;

    assign w_sym = {r_symbols_high, r_symbols_low};

    always_comb begin
        w_alpha_ok = 1'b1;
        if (r_symbol_count < 5'd2 || r_symbol_count > 5'(MAX_SYMBOLS)) begin
            w_alpha_ok = 1'b0;
        end
        for (int i = 0; i < 16; i++) begin
            if (5'(i) < r_symbol_count) begin
                if (w_sym[i] == CHAR_PLUS || w_sym[i] == CHAR_MINUS) begin
                    w_alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < 16; j++) begin
                    if (5'(j) < r_symbol_count && w_sym[j] == w_sym[i]) begin
                        w_alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // Restoring division by the radix, eight dividend bits per cycle; quotient bits
    // replace the dividend bits in place, and the quotient's bit length is tracked.
    always_comb begin
        logic [4:0] v_t;
        logic [4:0] v_idx;
        logic       v_q;
        w_work = r_work;
        w_rem  = r_rem;
        w_nlen = r_nlen;
        for (int k = 0; k < STEPS; k++) begin
            v_idx = 5'(r_cnt - 6'(k) - 6'd1);
            v_t   = {w_rem, w_work[v_idx]};
            v_q   = 1'b0;
            if (6'(k) < r_cnt) begin
                if (v_t >= r_symbol_count) begin
                    v_q = 1'b1;
                    v_t = v_t - r_symbol_count;
                end
                w_rem         = v_t[3:0];
                w_work[v_idx] = v_q;
                if (v_q && w_nlen == 6'd0) begin
                    w_nlen = {1'b0, v_idx} + 6'd1;
                end
            end
        end
        w_div_done = (r_cnt <= 6'(STEPS));
    end

    always_comb begin
        o_ready     = (r_state == ST_IDLE);
        w_start     = (r_state == ST_IDLE) && i_valid && w_alpha_ok;
        w_emit_load = (r_state == ST_EMIT) && (!r_ovalid || i_ready);
        w_last_load = w_emit_load && !r_neg && (r_nd == 6'd1);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done && w_nlen == 6'd0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_last_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_work   = r_work;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_nlen   = r_nlen;
        n_stack  = r_stack;
        n_nd     = r_nd;
        n_neg    = r_neg;
        n_ovalid = r_ovalid && !i_ready;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        if (w_start) begin
            n_work = i_value[31] ? (32'd0 - 32'(i_value)) : 32'(i_value);
            n_cnt  = 6'd32;
            n_rem  = 4'd0;
            n_nlen = 6'd0;
            n_nd   = 6'd0;
            n_neg  = i_value[31];
        end
        if (r_state == ST_DIV) begin
            n_work = w_work;
            n_rem  = w_rem;
            n_nlen = w_nlen;
            n_cnt  = r_cnt - 6'(STEPS);
            if (w_div_done) begin
                n_stack = {r_stack[DIGITS_MAX-2:0], w_rem};
                n_nd    = r_nd + 6'd1;
                n_cnt   = w_nlen;
                n_rem   = 4'd0;
                n_nlen  = 6'd0;
            end
        end
        if (w_emit_load) begin
            n_ovalid = 1'b1;
            if (r_neg) begin
                n_ochar = CHAR_MINUS;
                n_olast = 1'b0;
                n_neg   = 1'b0;
            end else begin
                n_ochar = w_sym[r_stack[0]];
                n_olast = (r_nd == 6'd1);
                n_stack = {t_digit'(4'd0), r_stack[DIGITS_MAX-1:1]};
                n_nd    = r_nd - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_ovalid       <= 1'b0;
            r_symbol_count <= RST_SYMBOL_COUNT;
            r_symbols_low  <= RST_SYMBOLS_LOW;
            r_symbols_high <= RST_SYMBOLS_HIGH;
            r_nd           <= 6'd0;
            r_neg          <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_nd     <= n_nd;
            r_neg    <= n_neg;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SYMBOL_COUNT: r_symbol_count <= i_cfg_data[4:0];
                    CFG_SYMBOLS_LOW:  r_symbols_low  <= i_cfg_data;
                    CFG_SYMBOLS_HIGH: r_symbols_high <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_work  <= n_work;
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_nlen  <= n_nlen;
        r_stack <= n_stack;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
    end

    assign o_valid    = r_ovalid;
    assign o_out_char = r_ochar;
    assign o_is_last  = r_olast;

    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> ({1'b0, r_rem} < r_symbol_count))
        else $error("Division remainder reached the radix.");

    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_nd != 6'd0))
        else $error("Emit phase entered with no digits stored.");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nd <= 6'(DIGITS_MAX))
        else $error("Digit stack overflow.");

    a_start_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && w_alpha_ok) |=> (r_state == ST_DIV))
        else $error("Accepted item with a valid alphabet did not start division.");

    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_load |=> (r_state == ST_IDLE && o_valid && o_is_last))
        else $error("Final character did not end the item.");

endmodule

// ===== tb/signed_int_to_radix_text_tb.sv =====
module signed_int_to_radix_text_tb;
    import sirt_pkg::*;

    localparam int MAX_SYMBOLS = 16;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 160;
    localparam int TAIL_CYCLES = 200;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  idx;
        logic [63:0] data;
        logic [31:0] value;
        logic        typed;
        logic [3:0]  n_chars;
        logic [87:0] text;
    } t_stim_row;

    typedef enum int {
        BAD_SHORT,
        BAD_LONG,
        BAD_MINUS,
        BAD_PLUS,
        BAD_REPEAT
    } t_bad_alphabet;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [63:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic               i_ready = 1'b1;
    logic [7:0]         o_out_char;
    logic               o_is_last;

    logic [4:0]  cur_count;
    logic [63:0] cur_low;
    logic [63:0] cur_high;

    t_text_char pending_chars[$];
    t_stim_row  stim_rows[$];
    int  error_count = 0;
    int  stall_left = 0;
    bit  quiet = 1'b0;
    bit  sent_since_settle = 1'b0;

    signed_int_to_radix_text #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_char (o_out_char),
        .o_is_last  (o_is_last)
    );

    initial forever #2 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [7:0] symbol_of(input int unsigned k);
        if (k < 8) begin
            return cur_low[8*k +: 8];
        end
        return cur_high[8*(k-8) +: 8];
    endfunction

    function automatic bit alphabet_usable();
        logic [7:0] c;
        if (cur_count < 2 || cur_count > MAX_SYMBOLS) begin
            return 1'b0;
        end
        for (int i = 0; i < cur_count; i++) begin
            c = symbol_of(i);
            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                return 1'b0;
            end
            for (int j = i + 1; j < cur_count; j++) begin
                if (symbol_of(j) == c) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic void expect_char(input logic [7:0] ch, input logic last);
        t_text_char c;
        c.ch = ch;
        c.last = last;
        pending_chars.push_back(c);
    endfunction

    function automatic void predict_text(input logic [31:0] raw);
        logic [31:0] mag;
        logic [3:0]  digs[32];
        int          nd;
        if (!alphabet_usable()) begin
            return;
        end
        if (raw == 32'd0) begin
            expect_char(symbol_of(0), 1'b1);
            return;
        end
        if (raw[31]) begin
            mag = 32'd0 - raw;
            expect_char(CHAR_MINUS, 1'b0);
        end else begin
            mag = raw;
        end
        nd = 0;
        while (mag != 32'd0) begin
            digs[nd] = 4'(mag % cur_count);
            mag = mag / cur_count;
            nd++;
        end
        for (int k = nd - 1; k >= 0; k--) begin
            expect_char(symbol_of(digs[k]), k == 0);
        end
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        longint      p;
        int unsigned radix;
        radix = (cur_count >= 2 && cur_count <= MAX_SYMBOLS) ? cur_count : 10;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 50);
            2: v = $urandom >> $urandom_range(0, 31);
            3: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h8000_0001;
                    default: v = 32'd0;
                endcase
            end
            default: begin
                p = 1;
                repeat ($urandom_range(0, 31)) begin
                    if (p * radix <= 64'h0000_0000_FFFF_FFFF) begin
                        p = p * radix;
                    end
                end
                v = 32'(p) - $urandom_range(0, 1);
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            v = 32'd0 - v;
        end
        return v;
    endfunction

    function automatic void add_cfg(input logic [1:0] idx, input logic [63:0] data);
        t_stim_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_value(input logic [31:0] v, input logic typed,
                                      input logic [3:0] n, input logic [87:0] text);
        t_stim_row r;
        r = '0;
        r.value = v;
        r.typed = typed;
        r.n_chars = n;
        r.text = text;
        stim_rows.push_back(r);
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic drain_expected();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_chars.size() != 0);
    endtask

    task automatic settle();
        if (sent_since_settle) begin
            drain_expected();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            sent_since_settle = 1'b0;
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SYMBOL_COUNT: cur_count = data[4:0];
            CFG_SYMBOLS_LOW:  cur_low = data;
            CFG_SYMBOLS_HIGH: cur_high = data;
            default: ;
        endcase
    endtask

    task automatic send_value(input logic [31:0] v);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
        sent_since_settle = 1'b1;
    endtask

    task automatic random_phase(input int n_items, input bit broken);
        logic [7:0]    syms[16];
        bit            used[256];
        int            cnt;
        int            i;
        int            j;
        logic [7:0]    c;
        logic [63:0]   low;
        logic [63:0]   high;
        logic [63:0]   cnt_data;
        logic [31:0]   v;
        t_bad_alphabet bad;
        settle();
        foreach (used[k]) begin
            used[k] = 1'b0;
        end
        case ($urandom_range(0, 3))
            0: cnt = 2;
            1: cnt = MAX_SYMBOLS;
            default: cnt = $urandom_range(2, MAX_SYMBOLS);
        endcase
        for (int k = 0; k < 16; k++) begin
            if (k < cnt) begin
                do c = 8'($urandom_range(0, 255));
                while (c == CHAR_PLUS || c == CHAR_MINUS || used[c]);
                used[c] = 1'b1;
            end else begin
                c = 8'($urandom_range(0, 255));
            end
            syms[k] = c;
        end
        if (broken) begin
            bad = t_bad_alphabet'($urandom_range(0, 4));
            i = $urandom_range(0, cnt - 2);
            j = $urandom_range(i + 1, cnt - 1);
            case (bad)
                BAD_SHORT:  cnt = $urandom_range(0, 1);
                BAD_LONG:   cnt = $urandom_range(MAX_SYMBOLS + 1, 31);
                BAD_MINUS:  syms[j] = CHAR_MINUS;
                BAD_PLUS:   syms[i] = CHAR_PLUS;
                BAD_REPEAT: syms[j] = syms[i];
                default: ;
            endcase
        end
        for (int k = 0; k < 8; k++) begin
            low[8*k +: 8] = syms[k];
            high[8*k +: 8] = syms[k+8];
        end
        cnt_data = {$urandom, $urandom};
        cnt_data[4:0] = 5'(cnt);
        if ($urandom_range(0, 3) == 0) begin
            cfg_write(CFG_UNUSED, {$urandom, $urandom});
        end
        if ($urandom_range(0, 1) == 0) begin
            cfg_write(CFG_SYMBOL_COUNT, cnt_data);
            cfg_write(CFG_SYMBOLS_LOW, low);
            cfg_write(CFG_SYMBOLS_HIGH, high);
        end else begin
            cfg_write(CFG_SYMBOLS_HIGH, high);
            cfg_write(CFG_SYMBOLS_LOW, low);
            cfg_write(CFG_SYMBOL_COUNT, cnt_data);
        end
        for (int n = 0; n < n_items; n++) begin
            if (!quiet && $urandom_range(0, 59) == 0) begin
                drain_expected();
            end
            v = pick_value();
            send_value(v);
            predict_text(v);
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : char_check
        t_text_char want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_chars.size() == 0) begin
                report_error($sformatf("unexpected char %h last %b", o_out_char, o_is_last));
            end else begin
                want = pending_chars.pop_front();
                if (o_out_char !== want.ch || o_is_last !== want.last) begin
                    report_error($sformatf("char expected %h last %b, got %h last %b",
                                           want.ch, want.last, o_out_char, o_is_last));
                end
            end
        end
    end

    initial begin
        t_stim_row r;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_SYMBOL_COUNT;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_value = '0;
        cur_count = RST_SYMBOL_COUNT;
        cur_low = RST_SYMBOLS_LOW;
        cur_high = RST_SYMBOLS_HIGH;

        // Decimal alphabet left by reset.
        add_value(32'd0, 1'b1, 4'd1, "0");
        add_value(32'h7FFF_FFFF, 1'b1, 4'd10, "2147483647");
        add_value(32'h8000_0000, 1'b1, 4'd11, "-2147483648");
        add_value(32'hFFFF_FFFF, 1'b1, 4'd2, "-1");
        add_value(32'd1, 1'b1, 4'd1, "1");
        add_value(32'd1000000000, 1'b1, 4'd10, "1000000000");
        // Full sixteen-symbol hex alphabet.
        add_cfg(CFG_SYMBOL_COUNT, 64'd16);
        add_cfg(CFG_SYMBOLS_HIGH, 64'h6665_6463_6261_3938);
        add_value(32'h7FFF_FFFF, 1'b0, 4'd0, '0);
        add_value(32'h8000_0000, 1'b0, 4'd0, '0);
        add_value(32'hDEAD_BEEF, 1'b0, 4'd0, '0);
        add_value(32'd15, 1'b0, 4'd0, '0);
        // Binary, with junk in the upper bits of the count write.
        add_cfg(CFG_SYMBOL_COUNT, 64'hFFFF_FFFF_FFFF_FFE2);
        add_value(32'h8000_0000, 1'b0, 4'd0, '0);
        add_value(32'h7FFF_FFFF, 1'b0, 4'd0, '0);
        add_value(32'd0, 1'b1, 4'd1, "0");
        add_value(32'hFFFF_FFFB, 1'b0, 4'd0, '0);
        // Alphabets that must produce no text.
        add_cfg(CFG_SYMBOL_COUNT, 64'd1);
        add_value(32'd5, 1'b1, 4'd0, '0);
        add_cfg(CFG_SYMBOL_COUNT, 64'd0);
        add_value(32'hFFFF_FFFB, 1'b1, 4'd0, '0);
        add_cfg(CFG_SYMBOL_COUNT, 64'd17);
        add_value(32'd1, 1'b1, 4'd0, '0);
        add_cfg(CFG_SYMBOL_COUNT, 64'd31);
        add_value(32'd0, 1'b1, 4'd0, '0);
        add_cfg(CFG_SYMBOL_COUNT, 64'd16);
        add_cfg(CFG_SYMBOLS_HIGH, 64'h3065_6463_6261_3938);
        add_value(32'd77, 1'b1, 4'd0, '0);
        add_cfg(CFG_SYMBOLS_HIGH, 64'h6665_6463_6261_3938);
        add_cfg(CFG_SYMBOLS_LOW, 64'h3736_3534_2D32_3130);
        add_value(32'hFFFF_FFB3, 1'b1, 4'd0, '0);
        add_cfg(CFG_SYMBOLS_LOW, 64'h3736_3534_3332_3130);
        add_cfg(CFG_SYMBOLS_HIGH, 64'h2B65_6463_6261_3938);
        add_value(32'd9, 1'b1, 4'd0, '0);
        // Valid again; a write to the unused index must change nothing.
        add_cfg(CFG_SYMBOLS_HIGH, 64'h6665_6463_6261_3938);
        add_cfg(CFG_UNUSED, 64'h2B2D_2B2D_0000_0001);
        add_value(32'd255, 1'b0, 4'd0, '0);
        // Ternary with a zero byte symbol and forbidden bytes past the count.
        add_cfg(CFG_SYMBOL_COUNT, 64'd3);
        add_cfg(CFG_SYMBOLS_LOW, 64'h0000_612B_2D7A_0061);
        add_cfg(CFG_SYMBOLS_HIGH, 64'h2D2B_2D2B_2D2B_2D2B);
        add_value(32'hFFFF_FFF9, 1'b0, 4'd0, '0);
        add_value(32'd100, 1'b0, 4'd0, '0);
        add_value(32'd0, 1'b0, 4'd0, '0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            r = stim_rows[k];
            if (r.is_cfg) begin
                settle();
                cfg_write(r.idx, r.data);
            end else begin
                send_value(r.value);
                if (r.typed) begin
                    for (int m = 0; m < r.n_chars; m++) begin
                        expect_char(r.text[8*(r.n_chars-1-m) +: 8], m == r.n_chars - 1);
                    end
                end else begin
                    predict_text(r.value);
                end
            end
        end

        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 8) begin
                quiet = 1'b1;
            end
            random_phase(40, 1'b0);
            if (ph == 2 || ph == 5) begin
                random_phase(4, 1'b1);
            end
        end

        drain_expected();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
